// ===== rtl/core/mau_pkg.sv =====
// Shared types and constants of the modular arithmetic unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package mau_pkg;

	// Operand, modulus and product widths.
	localparam int OP_W   = 32;
	localparam int MOD_W  = 31;
	localparam int PROD_W = 2 * MOD_W;
	localparam int RED_W  = 2 * OP_W;
	localparam int CNT_W  = $clog2(RED_W);
	localparam int FUNC_W = 3;

	// Reset value of the modulus register.
	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

	// Configuration register indexes (word address).
	localparam logic REG_MODULUS = 1'b0;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
	localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POW = 3'd3;
	localparam logic [FUNC_W-1:0] FN_DIV = 3'd4;

	// Sources of the result register.
	localparam logic [2:0] RS_ZERO   = 3'd0;
	localparam logic [2:0] RS_ONE    = 3'd1;
	localparam logic [2:0] RS_ADDSUB = 3'd2;
	localparam logic [2:0] RS_ACC    = 3'd3;
	localparam logic [2:0] RS_LANE0  = 3'd4;

	// Operand selection of the multipliers.
	localparam logic [1:0] MS_MUL = 2'd0;
	localparam logic [1:0] MS_POW = 2'd1;
	localparam logic [1:0] MS_FIN = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       red_ops;
		logic       red_fix;
		logic       red_prod;
		logic       mul_load;
		logic [1:0] mul_sel;
		logic       pow_init;
		logic       pow_step;
		logic       res_set;
		logic [2:0] res_src;
		logic       out_load;
	} mau_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              m_zero;
		logic              m_one;
		logic              b_nonpos;
		logic              rb_zero;
		logic              exp_zero;
		logic              lane_done;
	} mau_sts_t;

endpackage

// ===== rtl/core/modular_arithmetic_unit.sv =====
// Top level of the modular arithmetic unit: configuration register, controller
// and datapath. Depends on mau_pkg, mau_ctrl, mau_datapath.
//
// Usage: a request (func, operand_a, operand_b) is taken on in_valid/in_ready;
// its residue in [0, modulus), or zero for a zero modulus, leaves on
// out_valid/out_ready as result. The modulus is written over the APB port at
// byte address 0 (pready is always high) and must only change while no
// request is in flight. Every request first reduces both operands in two
// remainder lanes; add, subtract and the early-out cases then finish. Multiply
// forms the product of the residues and reduces it. Power runs square and
// multiply over the exponent bits; divide does the same with exponent
// modulus - 2 to form the inverse of the divisor, then multiplies the
// dividend by it. Each exponent bit needs two multiplies and a 64-step
// bit-serial remainder in two lanes running side by side. One request is
// worked at a time.
// The result sits in an output register: the next request is accepted while it
// waits, and finishes only once the receiver has taken it.
// Reset returns the controller to idle, drops out_valid and sets the modulus
// to 1000000007.
`timescale 1ns / 1ps

module modular_arithmetic_unit import mau_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// Request channel.
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [FUNC_W-1:0]      func,
	input  logic signed [OP_W-1:0] operand_a,
	input  logic signed [OP_W-1:0] operand_b,
	// Result channel.
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [MOD_W-1:0]       result
);

	logic [MOD_W-1:0] modulus_q;
	mau_cmd_t         cmd;
	mau_sts_t         sts;

	assign pready = 1'b1;

	// Modulus register, written in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODULUS)) begin
			modulus_q <= pwdata[MOD_W-1:0];
		end
	end

	// Register read-back.
	always_comb begin
		if (paddr[2] == REG_MODULUS) begin
			prdata = {{(32-MOD_W){1'b0}}, modulus_q};
		end else begin
			prdata = '0;
		end
	end

	mau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mau_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.modulus   (modulus_q),
		.func      (func),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

// ===== rtl/core/mau_reducer.sv =====
// Bit-serial remainder unit: x mod m, one dividend bit per cycle.
// Depends on mau_pkg.
`timescale 1ns / 1ps

module mau_reducer import mau_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RED_W-1:0] x,
	input  logic [CNT_W-1:0] last,
	input  logic [MOD_W-1:0] m,
	output logic             done,
	output logic [MOD_W-1:0] rem
);

	logic [RED_W-1:0] shift_q;
	logic [MOD_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] last_q;
	logic             busy_q;
	logic             done_q;
	logic [MOD_W:0]   trial;
	logic [MOD_W:0]   diff;
	logic [MOD_W-1:0] rem_next;

	// One restoring step: shift in the next bit and subtract the modulus if it fits.
	always_comb begin
		trial    = {rem_q, shift_q[RED_W-1]};
		diff     = trial - {1'b0, m};
		rem_next = (trial >= {1'b0, m}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Dividend shifter and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= x;
			rem_q   <= '0;
			last_q  <= last;
		end else if (busy_q) begin
			shift_q <= {shift_q[RED_W-2:0], 1'b0};
			rem_q   <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

`ifndef ASSERT_OFF
	// A new reduction is never started on top of a running one.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("reducer restarted while busy");

	// Completion is flagged only once the iteration has stopped.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("reducer flagged done while still busy");

	// The step counter never runs past the last bit.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= last_q))
		else $error("reducer step counter out of range");
`endif

endmodule

// ===== rtl/core/mau_datapath.sv =====
// Datapath of the modular arithmetic unit: operand registers, multipliers,
// two remainder lanes and the result registers. Depends on mau_pkg, mau_reducer.
`timescale 1ns / 1ps

module mau_datapath import mau_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [MOD_W-1:0]        modulus,
	input  logic [FUNC_W-1:0]       func,
	input  logic signed [OP_W-1:0]  operand_a,
	input  logic signed [OP_W-1:0]  operand_b,
	input  mau_cmd_t                cmd,
	output mau_sts_t                sts,
	output logic [MOD_W-1:0]        result
);

	logic [FUNC_W-1:0] func_q;
	logic [OP_W-1:0]   a_q;
	logic [OP_W-1:0]   b_q;
	logic [MOD_W-1:0]  ra_q;
	logic [MOD_W-1:0]  rb_q;
	logic [MOD_W-1:0]  acc_q;
	logic [MOD_W-1:0]  base_q;
	logic [MOD_W-1:0]  exp_q;
	logic [PROD_W-1:0] p0_q;
	logic [PROD_W-1:0] p1_q;
	logic [MOD_W-1:0]  res_q;
	logic [MOD_W-1:0]  out_q;

	logic [OP_W-1:0]   mag_a;
	logic [OP_W-1:0]   mag_b;
	logic [RED_W-1:0]  x0;
	logic [RED_W-1:0]  x1;
	logic [CNT_W-1:0]  last;
	logic              red_start;
	logic              done0;
	logic              done1;
	logic [MOD_W-1:0]  r0;
	logic [MOD_W-1:0]  r1;
	logic [MOD_W-1:0]  mx;
	logic [MOD_W-1:0]  my;
	logic [MOD_W-1:0]  one_mod;
	logic [OP_W-1:0]   sum;
	logic [OP_W-1:0]   sum_red;
	logic [MOD_W-1:0]  addsub;

	// Residue of a signed operand from the remainder of its magnitude.
	function automatic logic [MOD_W-1:0] fix_sign(input logic neg, input logic [MOD_W-1:0] r,
		input logic [MOD_W-1:0] m);
		fix_sign = (neg && (r != '0)) ? (m - r) : r;
	endfunction

	// Magnitudes of the operands; the most negative value maps to 2^(OP_W-1).
	assign mag_a = a_q[OP_W-1] ? (~a_q + 1'b1) : a_q;
	assign mag_b = b_q[OP_W-1] ? (~b_q + 1'b1) : b_q;

	// Lane inputs: operands top-aligned for a short run, products for a full run.
	assign x0        = cmd.red_ops ? {mag_a, {OP_W{1'b0}}} : {{(RED_W-PROD_W){1'b0}}, p0_q};
	assign x1        = cmd.red_ops ? {mag_b, {OP_W{1'b0}}} : {{(RED_W-PROD_W){1'b0}}, p1_q};
	assign last      = cmd.red_ops ? CNT_W'(OP_W - 1) : CNT_W'(RED_W - 1);
	assign red_start = cmd.red_ops | cmd.red_prod;

	mau_reducer u_lane0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.x      (x0),
		.last   (last),
		.m      (modulus),
		.done   (done0),
		.rem    (r0)
	);

	mau_reducer u_lane1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.x      (x1),
		.last   (last),
		.m      (modulus),
		.done   (done1),
		.rem    (r1)
	);

	// Operand selection of the first multiplier; the second always squares the base.
	always_comb begin
		case (cmd.mul_sel)
			MS_MUL: begin
				mx = ra_q;
				my = rb_q;
			end
			MS_POW: begin
				mx = acc_q;
				my = base_q;
			end
			MS_FIN: begin
				mx = ra_q;
				my = acc_q;
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	// Add and subtract need a single conditional subtraction.
	always_comb begin
		one_mod = {{(MOD_W-1){1'b0}}, (modulus != MOD_W'(1))};
		if (func_q == FN_SUB) begin
			sum = {1'b0, ra_q} + ({1'b0, modulus} - {1'b0, rb_q});
		end else begin
			sum = {1'b0, ra_q} + {1'b0, rb_q};
		end
		sum_red = sum - {1'b0, modulus};
		addsub  = (sum >= {1'b0, modulus}) ? sum_red[MOD_W-1:0] : sum[MOD_W-1:0];
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			a_q    <= operand_a;
			b_q    <= operand_b;
		end
		if (cmd.red_fix) begin
			ra_q <= fix_sign(a_q[OP_W-1], r0, modulus);
			rb_q <= fix_sign(b_q[OP_W-1], r1, modulus);
		end
		if (cmd.mul_load) begin
			p0_q <= {{MOD_W{1'b0}}, mx} * {{MOD_W{1'b0}}, my};
			p1_q <= {{MOD_W{1'b0}}, base_q} * {{MOD_W{1'b0}}, base_q};
		end
		if (cmd.pow_init) begin
			acc_q <= one_mod;
			if (func_q == FN_DIV) begin
				base_q <= rb_q;
				exp_q  <= modulus - MOD_W'(2);
			end else begin
				base_q <= ra_q;
				exp_q  <= b_q[MOD_W-1:0];
			end
		end else if (cmd.pow_step) begin
			if (exp_q[0]) begin
				acc_q <= r0;
			end
			base_q <= r1;
			exp_q  <= {1'b0, exp_q[MOD_W-1:1]};
		end
		if (cmd.res_set) begin
			case (cmd.res_src)
				RS_ZERO:   res_q <= '0;
				RS_ONE:    res_q <= one_mod;
				RS_ADDSUB: res_q <= addsub;
				RS_ACC:    res_q <= acc_q;
				RS_LANE0:  res_q <= r0;
				default:   res_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// Status for the controller.
	always_comb begin
		sts.func      = func_q;
		sts.m_zero    = (modulus == '0);
		sts.m_one     = (modulus == MOD_W'(1));
		sts.b_nonpos  = b_q[OP_W-1] || (b_q == '0);
		sts.rb_zero   = (rb_q == '0);
		sts.exp_zero  = (exp_q == '0);
		sts.lane_done = done0 & done1;
	end

	assign result = out_q;

endmodule

// ===== rtl/core/mau_ctrl.sv =====
// Controller of the modular arithmetic unit: sequences reduction, multiply
// and square-and-multiply steps, and owns the handshakes. Depends on mau_pkg.
`timescale 1ns / 1ps

module mau_ctrl import mau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  mau_sts_t sts,
	output mau_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_RED_START = 4'd1;
	localparam logic [3:0] ST_RED_WAIT  = 4'd2;
	localparam logic [3:0] ST_DISPATCH  = 4'd3;
	localparam logic [3:0] ST_MUL_LOAD  = 4'd4;
	localparam logic [3:0] ST_MUL_START = 4'd5;
	localparam logic [3:0] ST_MUL_WAIT  = 4'd6;
	localparam logic [3:0] ST_POW_CHECK = 4'd7;
	localparam logic [3:0] ST_POW_LOAD  = 4'd8;
	localparam logic [3:0] ST_POW_START = 4'd9;
	localparam logic [3:0] ST_POW_WAIT  = 4'd10;
	localparam logic [3:0] ST_FIN       = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = ST_RED_START;
				end
			end
			ST_RED_START: begin
				cmd.red_ops = 1'b1;
				state_d     = ST_RED_WAIT;
			end
			ST_RED_WAIT: begin
				if (sts.lane_done) begin
					cmd.red_fix = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				cmd.res_src = RS_ZERO;
				if (sts.m_zero || (sts.func > FN_DIV)) begin
					cmd.res_set = 1'b1;
					state_d     = ST_FIN;
				end else begin
					case (sts.func)
						FN_ADD, FN_SUB: begin
							cmd.res_set = 1'b1;
							cmd.res_src = RS_ADDSUB;
							state_d     = ST_FIN;
						end
						FN_MUL: begin
							state_d = ST_MUL_LOAD;
						end
						FN_POW: begin
							if (sts.b_nonpos) begin
								cmd.res_set = 1'b1;
								cmd.res_src = RS_ONE;
								state_d     = ST_FIN;
							end else begin
								cmd.pow_init = 1'b1;
								state_d      = ST_POW_CHECK;
							end
						end
						default: begin
							// Divide: a zero divisor or a trivial modulus gives zero.
							if (sts.rb_zero || sts.m_one) begin
								cmd.res_set = 1'b1;
								state_d     = ST_FIN;
							end else begin
								cmd.pow_init = 1'b1;
								state_d      = ST_POW_CHECK;
							end
						end
					endcase
				end
			end
			ST_MUL_LOAD: begin
				cmd.mul_load = 1'b1;
				cmd.mul_sel  = (sts.func == FN_MUL) ? MS_MUL : MS_FIN;
				state_d      = ST_MUL_START;
			end
			ST_MUL_START: begin
				cmd.red_prod = 1'b1;
				state_d      = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (sts.lane_done) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RS_LANE0;
					state_d     = ST_FIN;
				end
			end
			ST_POW_CHECK: begin
				if (!sts.exp_zero) begin
					state_d = ST_POW_LOAD;
				end else if (sts.func == FN_POW) begin
					cmd.res_set = 1'b1;
					cmd.res_src = RS_ACC;
					state_d     = ST_FIN;
				end else begin
					// Divide: multiply the dividend by the inverse just formed.
					state_d = ST_MUL_LOAD;
				end
			end
			ST_POW_LOAD: begin
				cmd.mul_load = 1'b1;
				cmd.mul_sel  = MS_POW;
				state_d      = ST_POW_START;
			end
			ST_POW_START: begin
				cmd.red_prod = 1'b1;
				state_d      = ST_POW_WAIT;
			end
			ST_POW_WAIT: begin
				if (sts.lane_done) begin
					cmd.pow_step = 1'b1;
					state_d      = ST_POW_CHECK;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// The output register is only overwritten once its result has gone.
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result overwritten before it was taken");

	// A lane completes only while the controller is waiting for it.
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.lane_done |-> (state_q == ST_RED_WAIT || state_q == ST_MUL_WAIT ||
			state_q == ST_POW_WAIT))
		else $error("reduction finished outside a wait state");

	// An accepted request always starts with the operand reduction.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RED_START))
		else $error("accepted request did not start reduction");

	// A produced result is presented in the following cycle.
	a_out_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");
`endif

endmodule

// ===== tb/modular_arithmetic_unit_tb.sv =====
// Self-checking testbench of the modular arithmetic unit: directed and random requests,
// APB writes of the modulus, and a result check against a behavioural residue predictor.
// Depends on mau_pkg and modular_arithmetic_unit.
`timescale 1ns / 1ps

module modular_arithmetic_unit_tb import mau_pkg::*; ();

	typedef struct {
		logic [FUNC_W-1:0]      func;
		logic signed [OP_W-1:0] a;
		logic signed [OP_W-1:0] b;
	} arith_req_t;

	localparam logic [FUNC_W-1:0] OP_CODES [5] = '{FN_ADD, FN_SUB, FN_MUL, FN_POW, FN_DIV};
	localparam int HOLD_CYCLES = 5000;
	localparam int HOLD_AFTER  = 40;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   psel      = 1'b0;
	logic                   penable   = 1'b0;
	logic                   pwrite    = 1'b0;
	logic [2:0]             paddr     = '0;
	logic [31:0]            pwdata    = '0;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [FUNC_W-1:0]      func      = '0;
	logic signed [OP_W-1:0] operand_a = '0;
	logic signed [OP_W-1:0] operand_b = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [MOD_W-1:0]       result;

	arith_req_t       pending_reqs [$];
	logic [MOD_W-1:0] expected_residues [$];
	arith_req_t       next_req;
	logic [MOD_W-1:0] modulus_cfg = MOD_RESET;
	logic             req_taken = 1'b0;
	int               reqs_queued = 0;
	int               results_seen = 0;
	int               errors = 0;
	int               send_idle_pct = 14;
	int               recv_idle_pct = 70;
	int               hold_left = 0;
	logic             hold_done = 1'b0;

	modular_arithmetic_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	// Free-running clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Mathematical residue of a signed operand, m at least one.
	function automatic longint unsigned residue_of(logic signed [OP_W-1:0] v,
			longint unsigned m);
		longint r;
		r = longint'(v) % longint'(m);
		if (r < 0) begin
			r += longint'(m);
		end
		return longint'(r);
	endfunction

	// Both factors are below 2^31, so the product fits in 64 bits.
	function automatic longint unsigned mod_mul(longint unsigned x, longint unsigned y,
			longint unsigned m);
		return (x * y) % m;
	endfunction

	// Square-and-multiply; an exponent of zero gives 1 mod m.
	function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		acc = 1 % m;
		while (e != 0) begin
			if (e[0]) begin
				acc = mod_mul(acc, base, m);
			end
			base = mod_mul(base, base, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	// Expected result of one request under the given modulus.
	function automatic logic [MOD_W-1:0] predict_residue(logic [FUNC_W-1:0] f,
			logic signed [OP_W-1:0] a, logic signed [OP_W-1:0] b, logic [MOD_W-1:0] m);
		longint unsigned mm;
		longint unsigned ra;
		longint unsigned rb;
		longint unsigned r;
		mm = m;
		if (mm == 0) begin
			return '0;
		end
		ra = residue_of(a, mm);
		rb = residue_of(b, mm);
		case (f)
			FN_ADD: r = (ra + rb) % mm;
			FN_SUB: r = (ra + mm - rb) % mm;
			FN_MUL: r = mod_mul(ra, rb, mm);
			FN_POW: r = (b <= 0) ? (1 % mm) : mod_pow(ra, longint'(b), mm);
			FN_DIV: r = (rb == 0 || mm < 2) ? 0 : mod_mul(ra, mod_pow(rb, mm - 2, mm), mm);
			default: r = 0;
		endcase
		return MOD_W'(r);
	endfunction

	// Request driver: holds an offered request until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				next_req = pending_reqs.pop_front();
				in_valid  <= 1'b1;
				func      <= next_req.func;
				operand_a <= next_req.a;
				operand_b <= next_req.b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, and one long hold-off so that the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Prediction on acceptance and comparison of each returned result.
	always @(posedge clk) begin
		logic [MOD_W-1:0] want;
		if (arst_n) begin
			req_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				expected_residues = {expected_residues,
						predict_residue(func, operand_a, operand_b, modulus_cfg)};
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_residues.size() == 0) begin
					$error("result: none expected, got %0d", result);
					errors++;
				end else begin
					want = expected_residues.pop_front();
					if (result !== want) begin
						$error("result: expected %0d, got %0d", want, result);
						errors++;
					end
				end
			end
		end
	end

	// Writes the modulus register over APB, then reads it back.
	task automatic write_modulus(input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_MODULUS, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		modulus_cfg = value[MOD_W-1:0];
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {1'b0, modulus_cfg}) begin
			$error("prdata: expected %0d, got %0d", {1'b0, modulus_cfg}, prdata);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic queue_req(input logic [FUNC_W-1:0] f, input logic signed [OP_W-1:0] a,
			input logic signed [OP_W-1:0] b);
		arith_req_t req;
		req.func = f;
		req.a    = a;
		req.b    = b;
		pending_reqs = {pending_reqs, req};
		reqs_queued++;
	endtask

	// Waits until every queued request has come back.
	task automatic wait_drained();
		while (results_seen != reqs_queued) begin
			@(negedge clk);
		end
	endtask

	// Operand mix: extremes, values near multiples of the modulus, small and full range.
	function automatic logic signed [OP_W-1:0] pick_operand(logic [MOD_W-1:0] m);
		longint v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: v = 0;
					1: v = 1;
					2: v = -1;
					3: v = 32'sh7fff_ffff;
					default: v = -64'sh8000_0000;
				endcase
			end
			1, 2: begin
				v = longint'($urandom_range(0, 2)) * longint'(m) + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1)) begin
					v = -v;
				end
			end
			3, 4: begin
				v = $urandom_range(0, 100);
				if ($urandom_range(0, 1)) begin
					v = -v;
				end
			end
			default: v = longint'($signed($urandom()));
		endcase
		return OP_W'(v);
	endfunction

	// Exponents: half small, some non-positive, some full range.
	function automatic logic signed [OP_W-1:0] pick_exponent();
		case ($urandom_range(0, 19))
			0, 1: return -OP_W'($urandom_range(1, 1000));
			2: return {1'b1, 31'($urandom())};
			3: return '0;
			4, 5, 6, 7, 8, 9, 10, 11, 12, 13: return OP_W'($urandom_range(1, 64));
			default: return $signed($urandom());
		endcase
	endfunction

	task automatic queue_random_req();
		int r;
		logic [FUNC_W-1:0] f;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			f = FUNC_W'($urandom_range(int'(FN_DIV) + 1, (1 << FUNC_W) - 1));
		end else begin
			f = OP_CODES[(r - 1) % 5];
		end
		queue_req(f, pick_operand(modulus_cfg),
				(f == FN_POW) ? pick_exponent() : pick_operand(modulus_cfg));
	endtask

	task automatic run_segment(input logic [31:0] mod_word, input int n, input int s_pct,
			input int r_pct);
		write_modulus(mod_word);
		@(posedge clk);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) begin
			queue_random_req();
		end
		wait_drained();
	endtask

	// Main sequence: reset, directed cases, then random segments under several moduli.
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset modulus: extremes, wide products, exponent and divisor corner cases, invalid codes.
		queue_req(FN_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff);
		queue_req(FN_ADD, 32'sh8000_0000, 32'sh8000_0000);
		queue_req(FN_SUB, 0, 1);
		queue_req(FN_SUB, 32'sh8000_0000, 32'sh7fff_ffff);
		queue_req(FN_MUL, 32'sh7fff_ffff, 32'sh7fff_ffff);
		queue_req(FN_MUL, -1, -1);
		queue_req(FN_MUL, 32'sh8000_0000, 32'sh7fff_ffff);
		queue_req(FN_POW, -2, 31);
		queue_req(FN_POW, 5, 0);
		queue_req(FN_POW, 5, -3);
		queue_req(FN_POW, 3, 32'sh7fff_ffff);
		queue_req(FN_DIV, 10, 0);
		queue_req(FN_DIV, 10, 1000000007);
		queue_req(FN_DIV, 32'sh8000_0000, -1);
		queue_req(FN_DIV + 3'd1, 32'sh7fff_ffff, 32'sh8000_0000);
		queue_req(FN_DIV + 3'd2, -1, -1);
		queue_req(FN_DIV + 3'd3, 1, 1);
		wait_drained();

		// A modulus of one makes every result zero.
		write_modulus(32'd1);
		@(posedge clk);
		queue_req(FN_ADD, 32'sh7fff_ffff, 1);
		queue_req(FN_POW, 7, 0);
		queue_req(FN_DIV, 7, 3);
		queue_req(FN_MUL, -5, 9);
		wait_drained();

		// With a modulus of two the inverse exponent is zero.
		write_modulus(32'd2);
		@(posedge clk);
		queue_req(FN_DIV, 3, 7);
		queue_req(FN_DIV, -5, 2);
		wait_drained();

		// Largest modulus, prime.
		write_modulus(32'h7fff_ffff);
		@(posedge clk);
		queue_req(FN_MUL, 32'sh8000_0000, 32'sh8000_0000);
		queue_req(FN_DIV, 32'sh7fff_fffe, 32'sh8000_0000);
		wait_drained();

		// Random segments: sender lightly and receiver heavily idle, then the reverse, then neither.
		run_segment(32'd97, 32, 14, 70);
		run_segment(32'h7fff_ffff, 32, 14, 70);
		run_segment(32'h8000_03e8, 32, 14, 70);
		run_segment($urandom(), 32, 70, 14);
		run_segment(32'd65521, 32, 70, 14);
		run_segment(32'd2, 32, 70, 14);
		run_segment(32'd1000000007, 32, 0, 0);
		run_segment(32'($urandom_range(1, 50)), 32, 0, 0);
		run_segment(32'h8000_0000, 32, 0, 0);

		// Let any stray result surface before the verdict.
		repeat (2500) @(posedge clk);
		if (errors == 0) begin
			$display("modular_arithmetic_unit_tb: PASS");
		end else begin
			$display("modular_arithmetic_unit_tb: FAIL");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("modular_arithmetic_unit_tb: FAIL");
		$finish;
	end

endmodule
